@@ src/rrt_pkg.sv @@
// Shared constants, types and register codes for the ring road traffic block.
package rrt_pkg;

    localparam int MAX_CARS = 1024;
    localparam int SLOT_W   = $clog2(MAX_CARS);
    localparam int CNT_W    = 11;
    localparam int POS_W    = 16;
    localparam int SPD_W    = 5;
    localparam int RND_W    = 32;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_ROAD_LENGTH    = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED      = 2'd1;
    localparam logic [1:0] REG_SLOW_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_CAR_COUNT      = 2'd3;

    localparam logic [POS_W-1:0] RST_ROAD_LENGTH    = 16'd1000;
    localparam logic [SPD_W-1:0] RST_MAX_SPEED      = 5'd5;
    localparam logic [RND_W-1:0] RST_SLOW_THRESHOLD = 32'd1288490188;
    localparam logic [CNT_W-1:0] RST_CAR_COUNT      = 11'd1;

    // Input word modes.
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [SPD_W-1:0] speed;
    } t_car;

    typedef struct packed {
        logic [POS_W-1:0] road_length;
        logic [SPD_W-1:0] max_speed;
        logic [RND_W-1:0] slow_threshold;
        logic [CNT_W-1:0] car_count;
    } t_cfg;

    typedef struct packed {
        logic             mode;
        logic [SLOT_W-1:0] car_slot;
        logic [POS_W-1:0] load_position;
        logic [SPD_W-1:0] load_speed;
        logic [RND_W-1:0] random_word;
    } t_in_word;

    typedef struct packed {
        logic [SLOT_W-1:0] out_slot;
        logic [POS_W-1:0] out_position;
        logic [SPD_W-1:0] out_speed;
        logic             end_of_step;
        logic             load_error;
    } t_out_word;

endpackage

@@ src/rrt_ifs.sv @@
// Valid/ready channel interfaces for input and result words.
interface rrt_in_if;
    import rrt_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rrt_out_if;
    import rrt_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/ring_road_traffic_update.sv @@
// Ring road traffic update: car table memory, update sequencer and result register.
// A load word is accepted, then its result moves on to the output register.
// An update word takes two dependent table reads (the car, then the car ahead), the
// 16-step remainder unit when a stored position lies beyond the road, the gap and
// move stages, and the hand-off to the output register.
// Synchronous active-low reset clears the sequencer, cursor, first-car position and
// the output valid flag; the car table holds nothing defined until cars are loaded.
module ring_road_traffic_update (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rrt_in_if.sink                     i_in,
    rrt_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rrt_pkg::APB_AW-1:0] paddr,
    input  logic [rrt_pkg::APB_DW-1:0] pwdata,
    output logic [rrt_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import rrt_pkg::*;

    // Sequencer states. An update walks through every one of them in order; a load
    // goes straight from idle to the hold state.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OWN,
        ST_AHEAD,
        ST_MOD,
        ST_GAP,
        ST_MOVE,
        ST_HOLD
    } t_state;

    t_cfg cfg;

    t_state            r_state;
    logic [SLOT_W-1:0] r_cursor;
    logic [POS_W-1:0]  r_first_old;
    logic [SLOT_W-1:0] r_cur;
    logic [SLOT_W-1:0] r_ahead;
    logic              r_last;
    logic [RND_W-1:0]  r_rnd;
    logic [POS_W-1:0]  r_own_raw;
    logic [SPD_W-1:0]  r_own_spd;
    logic [POS_W-1:0]  r_gap;
    logic [SPD_W-1:0]  r_vel;
    t_out_word         r_res;
    t_out_word         r_out;
    logic              r_out_v;

    // Effective configuration: a zero length counts as one, the car count is clamped.
    logic [POS_W-1:0]  len;
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] cur;
    logic [CNT_W-1:0]  ahead_idx;
    logic              last;
    logic              accept;
    logic              is_update;
    logic              bad_load;
    logic              out_free;

    // Table access.
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    t_car              ram_wdata;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
    t_car              ram_rdata;

    // Remainder unit.
    logic              mod_start;
    logic [POS_W-1:0]  ahead_raw;
    logic              mod_done;
    logic [POS_W-1:0]  own_pos;
    logic [POS_W-1:0]  ahead_pos;

    // Gap and move arithmetic.
    logic [POS_W:0]    gap_sum;
    logic [POS_W-1:0]  gap;
    logic [SPD_W-1:0]  vel_acc;
    logic [SPD_W-1:0]  vel_brk;
    logic [SPD_W-1:0]  vel_fin;
    logic [POS_W:0]    move_sum;
    logic [POS_W-1:0]  new_pos;

    rrt_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign len = (cfg.road_length == '0) ? POS_W'(1) : cfg.road_length;

    always_comb begin
        if (cfg.car_count == '0) begin
            count = CNT_W'(1);
        end else if (cfg.car_count > CNT_W'(MAX_CARS)) begin
            count = CNT_W'(MAX_CARS);
        end else begin
            count = cfg.car_count;
        end
    end

    // A cursor left beyond a lowered car count restarts the step at car zero.
    assign cur       = ({1'b0, r_cursor} < count) ? r_cursor : '0;
    assign ahead_idx = CNT_W'(cur) + CNT_W'(1);
    assign last      = (ahead_idx == count);

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid & i_in.ready;
    assign is_update  = (i_in.data.mode == MODE_UPDATE);
    assign bad_load   = (i_in.data.load_position >= len);
    assign out_free   = !r_out_v || o_out.ready;

    // The own entry is read in the accept cycle, the car ahead in the cycle after it.
    // Loads write directly at acceptance; updates write back in the move state.
    // Words are handled one at a time, so a read never overlaps a pending write.
    assign ram_re    = (accept && is_update) || (r_state == ST_OWN);
    assign ram_raddr = (r_state == ST_OWN) ? r_ahead : cur;
    assign ram_we    = (accept && !is_update && !bad_load) || (r_state == ST_MOVE);
    assign ram_waddr = (r_state == ST_MOVE) ? r_cur : i_in.data.car_slot;

    always_comb begin
        if (r_state == ST_MOVE) begin
            ram_wdata.position = new_pos;
            ram_wdata.speed    = vel_fin;
        end else begin
            ram_wdata.position = i_in.data.load_position;
            ram_wdata.speed    = i_in.data.load_speed;
        end
    end

    rrt_car_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The last car of a step sees car zero at the position it held before its own
    // update. When car zero is also the last car, that is the position just read.
    always_comb begin
        if (!r_last) begin
            ahead_raw = ram_rdata.position;
        end else if (r_cur == '0) begin
            ahead_raw = r_own_raw;
        end else begin
            ahead_raw = r_first_old;
        end
    end

    assign mod_start = (r_state == ST_AHEAD);

    rrt_mod_unit u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mod_start),
        .i_divisor (len),
        .i_a       (r_own_raw),
        .i_b       (ahead_raw),
        .o_done    (mod_done),
        .o_rem_a   (own_pos),
        .o_rem_b   (ahead_pos)
    );

    // Free cells ahead. Both positions are below the length, so the sum stays below
    // twice the length and one conditional subtract finishes the modulo.
    assign gap_sum = {1'b0, ahead_pos} + {1'b0, len} - (POS_W+1)'(1) - {1'b0, own_pos};
    assign gap     = (gap_sum >= {1'b0, len}) ? POS_W'(gap_sum - {1'b0, len})
                                              : gap_sum[POS_W-1:0];
    assign vel_acc = (r_own_spd < cfg.max_speed) ? r_own_spd + SPD_W'(1) : r_own_spd;

    // Brake to the gap, then the random slowdown, then move around the ring.
    assign vel_brk = ({{(POS_W-SPD_W){1'b0}}, r_vel} > r_gap) ? r_gap[SPD_W-1:0] : r_vel;
    assign vel_fin = (vel_brk != '0 && r_rnd < cfg.slow_threshold) ? vel_brk - SPD_W'(1)
                                                                  : vel_brk;
    assign move_sum = {1'b0, own_pos} + (POS_W+1)'(vel_fin);
    assign new_pos  = (move_sum >= {1'b0, len}) ? POS_W'(move_sum - {1'b0, len})
                                                : move_sum[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cursor    <= '0;
            r_first_old <= '0;
            r_out_v     <= 1'b0;
        end else begin
            // The output register empties when taken, unless a new word refills it.
            if (r_out_v && o_out.ready && !(r_state == ST_HOLD && out_free)) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (is_update) begin
                            r_cur   <= cur;
                            r_ahead <= ahead_idx[SLOT_W-1:0];
                            r_last  <= last;
                            r_rnd   <= i_in.data.random_word;
                            r_state <= ST_OWN;
                        end else begin
                            r_res.out_slot    <= i_in.data.car_slot;
                            r_res.end_of_step <= 1'b0;
                            r_res.load_error  <= bad_load;
                            if (bad_load) begin
                                r_res.out_position <= '0;
                                r_res.out_speed    <= '0;
                            end else begin
                                r_res.out_position <= i_in.data.load_position;
                                r_res.out_speed    <= i_in.data.load_speed;
                            end
                            r_state <= ST_HOLD;
                        end
                    end
                end
                ST_OWN: begin
                    r_own_raw <= ram_rdata.position;
                    r_own_spd <= ram_rdata.speed;
                    r_state   <= ST_AHEAD;
                end
                ST_AHEAD: begin
                    if (r_cur == '0) begin
                        r_first_old <= r_own_raw;
                    end
                    r_state <= ST_MOD;
                end
                ST_MOD: begin
                    if (mod_done) begin
                        r_state <= ST_GAP;
                    end
                end
                ST_GAP: begin
                    r_gap   <= gap;
                    r_vel   <= vel_acc;
                    r_state <= ST_MOVE;
                end
                ST_MOVE: begin
                    r_cursor           <= r_last ? '0 : r_ahead;
                    r_res.out_slot     <= r_cur;
                    r_res.out_position <= new_pos;
                    r_res.out_speed    <= vel_fin;
                    r_res.end_of_step  <= r_last;
                    r_res.load_error   <= 1'b0;
                    r_state            <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_out_v <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

endmodule

@@ src/rrt_car_ram.sv @@
// Car table memory: one write port, one read port with registered read data.
module rrt_car_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [rrt_pkg::SLOT_W-1:0] i_waddr,
    input  rrt_pkg::t_car              i_wdata,
    input  logic                       i_re,
    input  logic [rrt_pkg::SLOT_W-1:0] i_raddr,
    output rrt_pkg::t_car              o_rdata
);
    import rrt_pkg::*;

    t_car r_mem [MAX_CARS];
    t_car r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/rrt_mod_unit.sv @@
// Two-lane bit-serial remainder unit that reduces two positions modulo the road length.
module rrt_mod_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rrt_pkg::POS_W-1:0] i_divisor,
    input  logic [rrt_pkg::POS_W-1:0] i_a,
    input  logic [rrt_pkg::POS_W-1:0] i_b,
    output logic                      o_done,
    output logic [rrt_pkg::POS_W-1:0] o_rem_a,
    output logic [rrt_pkg::POS_W-1:0] o_rem_b
);
    import rrt_pkg::*;

    localparam int STEP_W = $clog2(POS_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [POS_W-1:0]  r_div;
    logic [POS_W-1:0]  r_qa;
    logic [POS_W-1:0]  r_qb;
    logic [POS_W-1:0]  r_ra;
    logic [POS_W-1:0]  r_rb;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic logic [POS_W-1:0] rem_step(input logic [POS_W-1:0] rem,
                                                  input logic             bit_in,
                                                  input logic [POS_W-1:0] d);
        logic [POS_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[POS_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_div <= i_divisor;
                r_cnt <= '0;
                if (i_a < i_divisor && i_b < i_divisor) begin
                    // Both already on the road: no reduction needed.
                    r_ra   <= i_a;
                    r_rb   <= i_b;
                    r_done <= 1'b1;
                end else begin
                    r_qa   <= i_a;
                    r_qb   <= i_b;
                    r_ra   <= '0;
                    r_rb   <= '0;
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                end
            end else if (r_busy) begin
                r_ra  <= rem_step(r_ra, r_qa[POS_W-1], r_div);
                r_rb  <= rem_step(r_rb, r_qb[POS_W-1], r_div);
                r_qa  <= {r_qa[POS_W-2:0], 1'b0};
                r_qb  <= {r_qb[POS_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(POS_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done  = r_done;
    assign o_rem_a = r_ra;
    assign o_rem_b = r_rb;

endmodule

@@ src/rrt_apb_regs.sv @@
// APB configuration registers of the ring road traffic block.
module rrt_apb_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rrt_pkg::APB_AW-1:0] paddr,
    input  logic [rrt_pkg::APB_DW-1:0] pwdata,
    output logic [rrt_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output rrt_pkg::t_cfg              o_cfg
);
    import rrt_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.road_length    <= RST_ROAD_LENGTH;
            r_cfg.max_speed      <= RST_MAX_SPEED;
            r_cfg.slow_threshold <= RST_SLOW_THRESHOLD;
            r_cfg.car_count      <= RST_CAR_COUNT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ROAD_LENGTH:    r_cfg.road_length    <= pwdata[POS_W-1:0];
                REG_MAX_SPEED:      r_cfg.max_speed      <= pwdata[SPD_W-1:0];
                REG_SLOW_THRESHOLD: r_cfg.slow_threshold <= pwdata[RND_W-1:0];
                REG_CAR_COUNT:      r_cfg.car_count      <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ROAD_LENGTH:    prdata = APB_DW'(r_cfg.road_length);
            REG_MAX_SPEED:      prdata = APB_DW'(r_cfg.max_speed);
            REG_SLOW_THRESHOLD: prdata = APB_DW'(r_cfg.slow_threshold);
            REG_CAR_COUNT:      prdata = APB_DW'(r_cfg.car_count);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the ring road traffic update block.
module testbench;
    import rrt_pkg::*;

    localparam int unsigned RANDOM_WORDS = 1650;
    // Cycles without any word moving or register access before the run is declared hung.
    localparam int unsigned IDLE_LIMIT   = 2000;
    // Settling time after the last result; an update with a stored position
    // beyond the road is the slowest kind of word.
    localparam int unsigned SETTLE       = 30;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    rrt_in_if  in_ch ();
    rrt_out_if out_ch ();

    ring_road_traffic_update dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the configuration registers.
    logic [POS_W-1:0] cfg_road_length    = RST_ROAD_LENGTH;
    logic [SPD_W-1:0] cfg_max_speed      = RST_MAX_SPEED;
    logic [RND_W-1:0] cfg_slow_threshold = RST_SLOW_THRESHOLD;
    logic [CNT_W-1:0] cfg_car_count      = RST_CAR_COUNT;

    // Predicted contents of the car table and the update sequencer.
    logic [POS_W-1:0]  road_pos [MAX_CARS];
    logic [SPD_W-1:0]  road_spd [MAX_CARS];
    bit                car_loaded [MAX_CARS];
    int unsigned       cursor = 0;
    logic [POS_W-1:0]  first_car_old_pos = '0;

    t_out_word   expected_cars [$];
    t_out_word   oldest_car;
    int unsigned mismatch_count = 0;
    int unsigned words_sent = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left = 0;
    bit          input_gaps_on = 1'b1;
    bit          output_stalls_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned road_cells();
        return (cfg_road_length == 0) ? 1 : cfg_road_length;
    endfunction

    function automatic int unsigned cars_in_use();
        if (cfg_car_count == 0) return 1;
        if (cfg_car_count > MAX_CARS) return MAX_CARS;
        return cfg_car_count;
    endfunction

    // A cursor left beyond the car count by a register change restarts at car 0.
    function automatic int unsigned next_car();
        return (cursor < cars_in_use()) ? cursor : 0;
    endfunction

    // Applies one input word to the shadow table and returns the result it causes.
    function automatic t_out_word advance_traffic(t_in_word w);
        t_out_word   r;
        int unsigned len, count, cur, ahead, own, vel, ahead_pos, gap;
        bit          last;
        r = '0;
        len = road_cells();
        if (w.mode == MODE_LOAD) begin
            r.out_slot = w.car_slot;
            if (w.load_position >= len) begin
                r.load_error = 1'b1;
                return r;
            end
            road_pos[w.car_slot] = w.load_position;
            road_spd[w.car_slot] = w.load_speed;
            car_loaded[w.car_slot] = 1'b1;
            r.out_position = w.load_position;
            r.out_speed = w.load_speed;
            return r;
        end
        count = cars_in_use();
        cur = next_car();
        ahead = cur + 1;
        last = (ahead == count);
        own = road_pos[cur];
        vel = road_spd[cur];
        // Car 0's old position is kept for the last car, whose car ahead is car 0.
        if (cur == 0) first_car_old_pos = POS_W'(own);
        ahead_pos = last ? first_car_old_pos : road_pos[ahead];
        own = own % len;
        ahead_pos = ahead_pos % len;
        if (vel < cfg_max_speed) vel++;
        gap = (ahead_pos + len - 1 - own) % len;
        if (vel > gap) vel = gap;
        if (vel > 0 && w.random_word < cfg_slow_threshold) vel--;
        road_pos[cur] = POS_W'((own + vel) % len);
        road_spd[cur] = SPD_W'(vel);
        cursor = last ? 0 : ahead;
        r.out_slot = SLOT_W'(cur);
        r.out_position = road_pos[cur];
        r.out_speed = road_spd[cur];
        r.end_of_step = last;
        return r;
    endfunction

    function automatic t_in_word make_load(int unsigned slot, int unsigned pos,
                                           int unsigned spd);
        t_in_word w;
        w.mode = MODE_LOAD;
        w.car_slot = SLOT_W'(slot);
        w.load_position = POS_W'(pos);
        w.load_speed = SPD_W'(spd);
        w.random_word = $urandom();
        return w;
    endfunction

    function automatic t_in_word make_update(logic [RND_W-1:0] rnd);
        t_in_word w;
        w.mode = MODE_UPDATE;
        w.car_slot = SLOT_W'($urandom());
        w.load_position = POS_W'($urandom());
        w.load_speed = SPD_W'($urandom());
        w.random_word = rnd;
        return w;
    endfunction

    // Sends one word; returns at the rising edge that accepted it.
    task automatic send_word(t_in_word w);
        int unsigned gap;
        @(negedge i_clk);
        gap = input_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_cars.push_back(advance_traffic(w));
        words_sent++;
    endtask

    // Parks the input and waits until every expected result has arrived.
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_cars.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ROAD_LENGTH:    cfg_road_length = value[POS_W-1:0];
            REG_MAX_SPEED:      cfg_max_speed = value[SPD_W-1:0];
            REG_SLOW_THRESHOLD: cfg_slow_threshold = value[RND_W-1:0];
            REG_CAR_COUNT:      cfg_car_count = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic reconfigure(int unsigned len, int unsigned max_spd,
                               logic [31:0] thr, int unsigned count);
        wait_idle();
        write_register(REG_ROAD_LENGTH, len);
        write_register(REG_MAX_SPEED, max_spd);
        write_register(REG_SLOW_THRESHOLD, thr);
        write_register(REG_CAR_COUNT, count);
    endtask

    // Updates the next car, first loading it and its car ahead if they were
    // never written, so no update ever reads an empty table entry.
    task automatic step_next_car(logic [RND_W-1:0] rnd);
        int unsigned cur, len;
        cur = next_car();
        len = road_cells();
        if (!car_loaded[cur])
            send_word(make_load(cur, $urandom_range(0, len - 1), $urandom_range(0, 31)));
        if (cur + 1 != cars_in_use() && !car_loaded[cur + 1])
            send_word(make_load(cur + 1, $urandom_range(0, len - 1),
                                $urandom_range(0, 31)));
        send_word(make_update(rnd));
    endtask

    // Loads cars 0..n-1 in ring order, one per stretch of road (random if len < n).
    task automatic place_cars(int unsigned n);
        int unsigned len, span, pos;
        len = road_cells();
        span = len / n;
        for (int unsigned i = 0; i < n; i++) begin
            pos = (span > 0) ? i * span + $urandom_range(0, span - 1)
                             : $urandom_range(0, len - 1);
            send_word(make_load(i, pos, $urandom_range(0, 31)));
        end
    endtask

    // A stray load: either rejected for its position or overwriting any slot.
    task automatic send_noise();
        int unsigned len;
        len = road_cells();
        if ($urandom_range(0, 1))
            send_word(make_load($urandom_range(0, 1023), $urandom_range(len, 65535),
                                $urandom_range(0, 31)));
        else
            send_word(make_load($urandom_range(0, 1023), $urandom_range(0, len - 1),
                                $urandom_range(0, 31)));
    endtask

    // Reset settings: a lone car loaded above the speed limit, both slowdown outcomes,
    // rejected loads at the road's end and at all-ones fields, and a valid load into slot 1023.
    task automatic test_default_single_car();
        send_word(make_load(0, 999, 31));
        send_word(make_update(32'h0000_0000));
        send_word(make_update(32'hFFFF_FFFF));
        send_word(make_load(5, 1000, 3));
        send_word(make_load(1023, 65535, 31));
        send_word(make_load(1023, 999, 31));
    endtask

    // Shortest roads and the register extremes, including a zero road length
    // and a zero car count, which behave as one.
    task automatic test_register_extremes();
        reconfigure(2, 31, 32'hFFFF_FFFF, 2);
        send_word(make_load(0, 0, 0));
        send_word(make_load(1, 1, 31));
        send_word(make_update(32'h0000_0000));
        send_word(make_update(32'h0000_0000));
        reconfigure(0, 0, 32'h0000_0000, 0);
        send_word(make_load(0, 0, 7));
        send_word(make_load(2, 1, 0));
        send_word(make_update($urandom()));
        send_word(make_update($urandom()));
    endtask

    // A car count above the table size is clipped; lowering the count below
    // the cursor makes the next update start again at car 0.
    task automatic test_stale_cursor();
        reconfigure(65535, 5, RST_SLOW_THRESHOLD, 2047);
        repeat (3) step_next_car($urandom());
        wait_idle();
        write_register(REG_CAR_COUNT, 2);
        repeat (2) step_next_car($urandom());
    endtask

    // Cars loaded far along a long road, then the road shortened beneath them.
    task automatic test_position_beyond_road();
        reconfigure(65535, 20, 32'h0000_0000, 3);
        send_word(make_load(0, 65000, 10));
        send_word(make_load(1, 65500, 2));
        send_word(make_load(2, 30000, 20));
        wait_idle();
        write_register(REG_ROAD_LENGTH, 97);
        repeat (3) step_next_car($urandom());
    endtask

    // Random phases: a fresh setting, usually a freshly placed ring of cars,
    // then several time steps with stray loads mixed in.
    task automatic test_random_traffic();
        int unsigned goal, n, len, max_spd, roll;
        logic [31:0] thr;
        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal) begin
            roll = $urandom_range(0, 99);
            n = (roll < 70) ? $urandom_range(1, 8) :
                (roll < 95) ? $urandom_range(9, 40) : $urandom_range(41, 120);
            roll = $urandom_range(0, 99);
            len = (roll < 60) ? $urandom_range(n < 2 ? 2 : n, n * 8 + 10) :
                  (roll < 80) ? $urandom_range(2, 65535) :
                  (roll < 90) ? 65535 : 2;
            roll = $urandom_range(0, 99);
            max_spd = (roll < 20) ? 0 : (roll < 40) ? 31 : $urandom_range(1, 10);
            roll = $urandom_range(0, 99);
            thr = (roll < 15) ? 32'h0000_0000 : (roll < 30) ? 32'hFFFF_FFFF : $urandom();
            reconfigure(len, max_spd, thr, n);
            input_gaps_on = ($urandom_range(0, 4) != 0);
            output_stalls_on = ($urandom_range(0, 4) != 0);
            // Now and then the old table is kept, so stored positions may now
            // lie beyond a shorter road.
            if ($urandom_range(0, 3) != 0) place_cars(n);
            repeat ($urandom_range(1, 6) * n) begin
                if (words_sent >= goal) break;
                if ($urandom_range(0, 9) == 0) send_noise();
                step_next_car($urandom());
            end
        end
        input_gaps_on = 1'b1;
        output_stalls_on = 1'b1;
    endtask

    // The result side stalls at random, in bursts of varied length.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if (output_stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Every accepted result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            if (expected_cars.size() == 0) begin
                $error("result word with no prediction waiting: slot %0d",
                       out_ch.data.out_slot);
                mismatch_count++;
            end else begin
                oldest_car = expected_cars.pop_front();
                compare_field("out_slot", oldest_car.out_slot, out_ch.data.out_slot);
                compare_field("out_position", oldest_car.out_position,
                              out_ch.data.out_position);
                compare_field("out_speed", oldest_car.out_speed, out_ch.data.out_speed);
                compare_field("end_of_step", oldest_car.end_of_step,
                              out_ch.data.end_of_step);
                compare_field("load_error", oldest_car.load_error,
                              out_ch.data.load_error);
            end
        end
    end

    // Hang detection: any moved word or register access counts as progress.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $error("no word moved for %0d cycles, %0d results outstanding",
                   IDLE_LIMIT, expected_cars.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_single_car();
        test_register_extremes();
        test_stale_cursor();
        test_position_beyond_road();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
